// ===== design/zcl_pkg.sv =====
`timescale 1ns / 1ps

package zcl_pkg;

	localparam int RING_DEPTH_DEFAULT = 8;

	localparam logic [15:0] CL_IAS_ZONE = 16'h0500;
	localparam logic [15:0] CL_OTA = 16'h0019;
	localparam logic [15:0] CL_ON_OFF = 16'h0006;
	localparam logic [15:0] PROFILE_HA = 16'h0104;
	localparam logic [1:0] FTYPE_MASK = 2'h3;
	localparam logic [1:0] FTYPE_CLUSTER = 2'h1;
	localparam int MANUF_BIT = 2;
	localparam int ALARM_BIT = 0;

	localparam logic [7:0] CMD_NONE = 8'hFF;
	localparam logic [7:0] CMD_ZONE_STATUS = 8'h00;
	localparam logic [7:0] CMD_ENROLL_REQ = 8'h01;
	localparam logic [7:0] CMD_OTA_QUERY = 8'h01;
	localparam logic [7:0] CMD_OFF = 8'h00;
	localparam logic [7:0] CMD_ON = 8'h01;
	localparam logic [7:0] CMD_TOGGLE = 8'h02;

	localparam logic [6:0] MIN_HDR_LEN = 7'd3;
	localparam logic [6:0] ZS_LEN_STD = 7'd5;
	localparam logic [6:0] ZS_LEN_MANUF = 7'd7;

	typedef struct packed {
		logic [15:0] source_addr;
		logic [7:0] source_endpoint;
		logic [15:0] cluster;
		logic [15:0] profile;
		logic [6:0] payload_length;
		logic [55:0] payload_head;
	} in_item_t;

	typedef struct packed {
		logic duplicate;
		logic button_press;
		logic enroll_request;
		logic [15:0] enroll_source;
		logic [7:0] enroll_endpoint;
		logic suppress_reply;
	} out_item_t;

	typedef struct packed {
		logic cs_frame;
		logic [7:0] tsn;
		logic [7:0] cmd;
		logic zone_status_ok;
		logic alarm;
	} hdr_t;

	typedef struct packed {
		logic [15:0] src;
		logic [15:0] cluster;
		logic [7:0] cmd;
		logic [7:0] tsn;
	} tuple_t;

endpackage

// ===== design/zcl_if.sv =====
`timescale 1ns / 1ps

interface zcl_in_if;
	logic valid;
	logic ready;
	zcl_pkg::in_item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface zcl_out_if;
	logic valid;
	logic ready;
	zcl_pkg::out_item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ===== design/zcl_frame_dedup_classifier.sv =====
`timescale 1ns / 1ps

// Classifies received ZCL frame descriptors and flags repeated frames.
// Descriptors arrive on the rx channel; one result per descriptor leaves on
// the tx channel, in order. Both channels use a valid/ready handshake, and a
// transaction completes on a clock edge where both are high.
// A descriptor accepted at one edge is held in the input register, checked
// against the ring of recently seen frames and classified in the next cycle,
// and its result moves into the output register once that register is free.
// The block takes one transaction per cycle while tx is not stalled; the ring
// lookup is combinational and the ring is written at the edge that moves the
// descriptor on, so the next descriptor already sees the updated ring.
// If the receiver holds tx.ready low, the result stays in the output register
// and one more descriptor waits in the input register; rx.ready then drops
// until tx moves again.
// Reset clears all ring entries at once, the ring write pointer and the
// stored IAS alarm level; the block is ready as soon as reset is released.

module zcl_frame_dedup_classifier #(
	parameter int RING_DEPTH = zcl_pkg::RING_DEPTH_DEFAULT
) (
	input logic clk,
	input logic arst_n,
	zcl_in_if.sink rx,
	zcl_out_if.source tx
);

	logic s1_valid_q;
	zcl_pkg::in_item_t item_s1;
	logic out_valid_q;
	zcl_pkg::out_item_t out_q;
	logic previous_alarm_q;

	logic advance;
	logic hit;
	logic wr_en;
	zcl_pkg::hdr_t hdr;
	zcl_pkg::tuple_t tuple;
	zcl_pkg::out_item_t result;
	logic zone_update;

	assign advance = s1_valid_q && (!out_valid_q || tx.ready);
	assign rx.ready = !s1_valid_q || advance;
	assign tx.valid = out_valid_q;
	assign tx.data = out_q;

	zcl_hdr_parse u_parse (
		.payload_length(item_s1.payload_length),
		.payload_head(item_s1.payload_head),
		.hdr(hdr)
	);

	assign tuple.src = item_s1.source_addr;
	assign tuple.cluster = item_s1.cluster;
	assign tuple.cmd = hdr.cmd;
	assign tuple.tsn = hdr.tsn;

	assign wr_en = advance && !hit;

	zcl_seen_ring #(
		.RING_DEPTH(RING_DEPTH)
	) u_ring (
		.clk(clk),
		.arst_n(arst_n),
		.tuple(tuple),
		.wr_en(wr_en),
		.hit(hit)
	);

	assign zone_update = !hit && hdr.cs_frame
		&& item_s1.cluster == zcl_pkg::CL_IAS_ZONE
		&& hdr.cmd == zcl_pkg::CMD_ZONE_STATUS && hdr.zone_status_ok;

	always_comb begin
		result = '0;
		result.duplicate = hit;
		if (!hit) begin
			if (zone_update) begin
				result.button_press = hdr.alarm && !previous_alarm_q;
			end else if (hdr.cs_frame && item_s1.cluster == zcl_pkg::CL_ON_OFF
				&& item_s1.profile == zcl_pkg::PROFILE_HA
				&& (hdr.cmd == zcl_pkg::CMD_OFF || hdr.cmd == zcl_pkg::CMD_ON
				|| hdr.cmd == zcl_pkg::CMD_TOGGLE)) begin
				result.button_press = 1'b1;
			end
			result.enroll_request = hdr.cs_frame
				&& item_s1.cluster == zcl_pkg::CL_IAS_ZONE
				&& hdr.cmd == zcl_pkg::CMD_ENROLL_REQ;
			result.suppress_reply = hdr.cs_frame
				&& item_s1.cluster == zcl_pkg::CL_OTA
				&& hdr.cmd == zcl_pkg::CMD_OTA_QUERY;
			if (result.enroll_request) begin
				result.enroll_source = item_s1.source_addr;
				result.enroll_endpoint = item_s1.source_endpoint;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
			previous_alarm_q <= 1'b0;
		end else begin
			if (rx.ready) begin
				s1_valid_q <= rx.valid;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (tx.ready) begin
				out_valid_q <= 1'b0;
			end
			if (advance && zone_update) begin
				previous_alarm_q <= hdr.alarm;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			item_s1 <= rx.data;
		end
		if (advance) begin
			out_q <= result;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		!rx.ready |-> (s1_valid_q && out_valid_q && !tx.ready))
		else $error("Input stalled without a blocked result.");

	assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("Advanced transaction did not reach the output register.");

	assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> hit || !s1_valid_q || item_s1 != $past(item_s1))
		else $error("Repeated frame was not caught after its ring write.");

	assert property (@(posedge clk) disable iff (!arst_n)
		(tx.valid && tx.data.duplicate) |-> (!tx.data.button_press
		&& !tx.data.enroll_request && !tx.data.suppress_reply))
		else $error("Duplicate frame raised an action.");

endmodule

// ===== design/zcl_hdr_parse.sv =====
`timescale 1ns / 1ps

module zcl_hdr_parse (
	input logic [6:0] payload_length,
	input logic [55:0] payload_head,
	output zcl_pkg::hdr_t hdr
);

	logic [7:0] fc;
	logic manuf;
	logic long_enough;

	assign fc = payload_head[7:0];
	assign manuf = fc[zcl_pkg::MANUF_BIT];
	assign long_enough = payload_length >= zcl_pkg::MIN_HDR_LEN;

	always_comb begin
		hdr = '0;
		hdr.cmd = zcl_pkg::CMD_NONE;
		if (long_enough) begin
			hdr.cs_frame = (fc[1:0] & zcl_pkg::FTYPE_MASK) == zcl_pkg::FTYPE_CLUSTER;
			if (manuf) begin
				hdr.tsn = payload_head[31:24];
				hdr.cmd = payload_head[39:32];
				hdr.zone_status_ok = payload_length >= zcl_pkg::ZS_LEN_MANUF;
				hdr.alarm = payload_head[40 + zcl_pkg::ALARM_BIT];
			end else begin
				hdr.tsn = payload_head[15:8];
				hdr.cmd = payload_head[23:16];
				hdr.zone_status_ok = payload_length >= zcl_pkg::ZS_LEN_STD;
				hdr.alarm = payload_head[24 + zcl_pkg::ALARM_BIT];
			end
		end
	end

endmodule

// ===== design/zcl_seen_ring.sv =====
`timescale 1ns / 1ps

module zcl_seen_ring #(
	parameter int RING_DEPTH = zcl_pkg::RING_DEPTH_DEFAULT
) (
	input logic clk,
	input logic arst_n,
	input zcl_pkg::tuple_t tuple,
	input logic wr_en,
	output logic hit
);

	localparam int HW = $clog2(RING_DEPTH);
	localparam logic [HW-1:0] LAST = HW'(RING_DEPTH - 1);

	logic [RING_DEPTH-1:0] valid_q;
	zcl_pkg::tuple_t tag_q [RING_DEPTH];
	logic [HW-1:0] head_q;
	logic [RING_DEPTH-1:0] match;

	always_comb begin
		for (int i = 0; i < RING_DEPTH; i++) begin
			match[i] = valid_q[i] && (tag_q[i] == tuple);
		end
	end

	assign hit = |match;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			head_q <= '0;
		end else if (wr_en) begin
			valid_q[head_q] <= 1'b1;
			head_q <= (head_q == LAST) ? '0 : head_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			tag_q[head_q] <= tuple;
		end
	end

endmodule
